### rtl/http_request_line_tokenizer_core_macros.svh
// Assertion macros used by the checker file of the tokenizer.
`ifndef HTTP_REQUEST_LINE_TOKENIZER_CORE_MACROS_SVH
`define HTTP_REQUEST_LINE_TOKENIZER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRLT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/hrlt_pkg.sv
`default_nettype none
package hrlt_pkg;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_LINE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] TOK_METHOD  = 2'd0;
   localparam logic [1:0] TOK_URI     = 2'd1;
   localparam logic [1:0] TOK_VERSION = 2'd2;

   localparam logic [1:0] ERR_NO_HEADER = 2'd0;

   localparam logic [1:0] CSR_MAX_METHOD_LEN  = 2'd0;
   localparam logic [1:0] CSR_MAX_URI_LEN     = 2'd1;
   localparam logic [1:0] CSR_MAX_VERSION_LEN = 2'd2;

   localparam logic [7:0]  RESET_MAX_METHOD_LEN  = 8'd32;
   localparam logic [14:0] RESET_MAX_URI_LEN     = 15'd16384;
   localparam logic [7:0]  RESET_MAX_VERSION_LEN = 8'd8;

   localparam logic [7:0] LF_BYTE = 8'h0A;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic       restart;
   } req_item_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [1:0] token_id;
      logic [7:0] token_byte;
      logic [1:0] error_code;
      logic       line_done;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  max_method_len;
      logic [14:0] max_uri_len;
      logic [7:0]  max_version_len;
   } limits_type;

   function automatic logic is_white(input logic [7:0] b);
      is_white = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

endpackage
`default_nettype wire

### rtl/hrlt_csr_regs.sv
`default_nettype none
module hrlt_csr_regs (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [14:0]        csr_wdata,
   output hrlt_pkg::limits_type    limits
);

   hrlt_pkg::limits_type limits_ff;
   hrlt_pkg::limits_type limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (csr_we) begin
         case (csr_index)
            hrlt_pkg::CSR_MAX_METHOD_LEN: begin
               limits_in.max_method_len = csr_wdata[7:0];
            end
            hrlt_pkg::CSR_MAX_URI_LEN: begin
               limits_in.max_uri_len = csr_wdata;
            end
            hrlt_pkg::CSR_MAX_VERSION_LEN: begin
               limits_in.max_version_len = csr_wdata[7:0];
            end
            default: begin
               limits_in = limits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_method_len  <= hrlt_pkg::RESET_MAX_METHOD_LEN;
         limits_ff.max_uri_len     <= hrlt_pkg::RESET_MAX_URI_LEN;
         limits_ff.max_version_len <= hrlt_pkg::RESET_MAX_VERSION_LEN;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule
`default_nettype wire

### rtl/hrlt_in_reg.sv
`default_nettype none
module hrlt_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tuser,
   input  wire logic                  advance,
   output logic                       item_valid,
   output hrlt_pkg::req_item_type     item
);

   logic                   valid_ff;
   logic                   valid_in;
   hrlt_pkg::req_item_type item_ff;
   logic                   take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte     <= req_tdata;
         item_ff.end_of_stream <= req_tlast;
         item_ff.restart       <= req_tuser;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

### rtl/hrlt_parser.sv
`default_nettype none
module hrlt_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire hrlt_pkg::req_item_type item,
   input  wire hrlt_pkg::limits_type  limits,
   output logic                       res_valid,
   output hrlt_pkg::rsp_item_type     res
);

   localparam logic [2:0] PH_SKIP_METHOD  = 3'd0;
   localparam logic [2:0] PH_METHOD       = 3'd1;
   localparam logic [2:0] PH_SKIP_URI     = 3'd2;
   localparam logic [2:0] PH_URI          = 3'd3;
   localparam logic [2:0] PH_SKIP_VERSION = 3'd4;
   localparam logic [2:0] PH_VERSION      = 3'd5;
   localparam logic [2:0] PH_DISCARD      = 3'd6;
   localparam logic [2:0] PH_IDLE         = 3'd7;

   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   logic [14:0] len_ff;
   logic [14:0] len_in;

   logic [2:0]  phase_base;
   logic [14:0] len_base;
   logic [1:0]  tok;
   logic [1:0]  tok_err;
   logic        white;
   logic [14:0] limit;
   logic [14:0] take_len;
   logic        too_long;

   always_comb begin
      phase_base = item.restart ? PH_SKIP_METHOD : phase_ff;
      len_base   = item.restart ? 15'd0 : len_ff;
      tok        = phase_base[2:1];
      tok_err    = tok + 2'd1;
      white      = hrlt_pkg::is_white(item.data_byte);
      case (tok)
         hrlt_pkg::TOK_METHOD: limit = {7'd0, limits.max_method_len};
         hrlt_pkg::TOK_URI:    limit = limits.max_uri_len;
         default:              limit = {7'd0, limits.max_version_len};
      endcase
      take_len = phase_base[0] ? len_base : 15'd0;
      too_long = take_len >= limit;
   end

   always_comb begin
      phase_in  = phase_base;
      len_in    = len_base;
      res_valid = 1'b0;
      res       = '0;
      case (phase_base)
         PH_SKIP_METHOD, PH_SKIP_URI, PH_SKIP_VERSION,
         PH_METHOD, PH_URI, PH_VERSION: begin
            res_valid      = 1'b1;
            res.token_id   = tok;
            if (item.end_of_stream) begin
               phase_in       = PH_IDLE;
               res.result_kind = hrlt_pkg::KIND_ERROR;
               res.error_code = (phase_base == PH_SKIP_METHOD) ?
                                hrlt_pkg::ERR_NO_HEADER : tok_err;
            end else if (!white) begin
               if (too_long) begin
                  phase_in        = PH_IDLE;
                  len_in          = take_len;
                  res.result_kind = hrlt_pkg::KIND_ERROR;
                  res.error_code  = tok_err;
               end else begin
                  phase_in        = {tok, 1'b1};
                  len_in          = take_len + 15'd1;
                  res.result_kind = hrlt_pkg::KIND_BYTE;
                  res.token_byte  = item.data_byte;
               end
            end else if (!phase_base[0]) begin
               res_valid = 1'b0;
            end else begin
               len_in          = 15'd0;
               res.result_kind = hrlt_pkg::KIND_END;
               if (phase_base == PH_VERSION) begin
                  if (item.data_byte == hrlt_pkg::LF_BYTE) begin
                     phase_in      = PH_IDLE;
                     res.line_done = 1'b1;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end else begin
                  phase_in = phase_base + 3'd1;
               end
            end
         end
         PH_DISCARD: begin
            if (item.end_of_stream || (item.data_byte == hrlt_pkg::LF_BYTE)) begin
               phase_in        = PH_IDLE;
               res_valid       = 1'b1;
               res.result_kind = hrlt_pkg::KIND_LINE;
               res.token_id    = hrlt_pkg::TOK_VERSION;
               res.line_done   = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP_METHOD;
         len_ff   <= 15'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
      end
   end

endmodule
`default_nettype wire

### rtl/http_request_line_tokenizer_core.sv
// An item waits in the input register, then its result in the rsp output register.
// Throughput: one item per cycle while rsp is not stalled; phase and length update per item.
// An item that yields no result still takes one pass through the input register.
// Reset is synchronous and active high; it clears both channels, the parse state and
// restores the length limits to 32, 16384 and 8.
`default_nettype none
module http_request_line_tokenizer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tlast,
   input  wire logic        req_tuser,   // restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // token_id, token_byte, error_code, zero fill
   output logic             rsp_tlast,
   output logic [1:0]       rsp_tuser,   // result_kind
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   hrlt_pkg::limits_type   limits;
   hrlt_pkg::req_item_type item;
   hrlt_pkg::rsp_item_type res;
   logic                   item_valid;
   logic                   res_valid;
   logic                   advance;
   logic                   out_free;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   hrlt_pkg::rsp_item_type rsp_item_ff;

   hrlt_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   hrlt_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hrlt_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item),
      .limits    (limits),
      .res_valid (res_valid),
      .res       (res)
   );

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign advance      = item_valid && out_free;
   assign rsp_valid_in = out_free ? (advance && res_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_item_ff.error_code, rsp_item_ff.token_byte,
                        rsp_item_ff.token_id};
   assign rsp_tlast  = rsp_item_ff.line_done;
   assign rsp_tuser  = rsp_item_ff.result_kind;

endmodule
`default_nettype wire

### rtl/hrlt_checker.sv
`default_nettype none
`include "http_request_line_tokenizer_core_macros.svh"
module hrlt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [1:0]  rsp_tuser
);

   `HRLT_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid, "rsp valid after reset")
   `HRLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp item changed under stall")
   `HRLT_ASSERT_IMPLY(a_byte_not_white, clock, reset, rsp_tvalid && (rsp_tuser == hrlt_pkg::KIND_BYTE), !hrlt_pkg::is_white(rsp_tdata[9:2]) && !rsp_tlast, "token byte is whitespace")
   `HRLT_ASSERT_IMPLY(a_line_shape, clock, reset, rsp_tvalid && (rsp_tuser == hrlt_pkg::KIND_LINE), rsp_tlast && (rsp_tdata[1:0] == hrlt_pkg::TOK_VERSION), "malformed line finished item")

endmodule

bind http_request_line_tokenizer_core hrlt_checker u_hrlt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

### verif/http_request_line_tokenizer_core_tb.sv
module http_request_line_tokenizer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      SEEK_METHOD,
      IN_METHOD,
      SEEK_URI,
      IN_URI,
      SEEK_VERSION,
      IN_VERSION,
      DISCARD_LINE,
      STOPPED
   } phase_type;

   typedef enum logic [1:0] {
      ENTRY_ITEM,
      ENTRY_CSR,
      ENTRY_DRAIN
   } entry_kind_type;

   typedef struct {
      entry_kind_type         kind;
      hrlt_pkg::req_item_type item;
      logic [1:0]             csr_index;
      logic [14:0]            csr_value;
   } entry_type;

   localparam logic [1:0] ERR_BAD_METHOD  = 2'd1;
   localparam logic [1:0] ERR_BAD_URI     = 2'd2;
   localparam logic [1:0] ERR_BAD_VERSION = 2'd3;

   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [14:0] csr_wdata = 15'd0;

   entry_type              pending_entries[$];
   hrlt_pkg::rsp_item_type expected_results[$];
   hrlt_pkg::req_item_type in_flight;

   // Predictor state and its copy of the length limits.
   phase_type   parse_phase = SEEK_METHOD;
   logic [14:0] token_len = '0;
   logic [7:0]  lim_method = hrlt_pkg::RESET_MAX_METHOD_LEN;
   logic [14:0] lim_uri = hrlt_pkg::RESET_MAX_URI_LEN;
   logic [7:0]  lim_version = hrlt_pkg::RESET_MAX_VERSION_LEN;

   // Limits as the stimulus generator plans them, indexed by token.
   int gen_lim[3];
   int planned_items = 0;
   bit restart_next = 1'b0;

   int failures = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int settle = 0;
   bit send_calm = 1'b0;
   int hold_off = 0;
   bit recv_calm = 1'b0;

   http_request_line_tokenizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bit is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic [1:0] bad_token_code(input logic [1:0] tok);
      case (tok)
         hrlt_pkg::TOK_METHOD: return ERR_BAD_METHOD;
         hrlt_pkg::TOK_URI:    return ERR_BAD_URI;
         default:              return ERR_BAD_VERSION;
      endcase
   endfunction

   function automatic bit take_token_byte(input logic [1:0] tok, input logic [7:0] b,
                                          output hrlt_pkg::rsp_item_type r);
      logic [14:0] lim;
      r = '0;
      case (tok)
         hrlt_pkg::TOK_METHOD: lim = {7'd0, lim_method};
         hrlt_pkg::TOK_URI:    lim = lim_uri;
         default:              lim = {7'd0, lim_version};
      endcase
      r.token_id = tok;
      if (token_len >= lim) begin
         parse_phase = STOPPED;
         r.result_kind = hrlt_pkg::KIND_ERROR;
         r.error_code = bad_token_code(tok);
         return 1'b1;
      end
      token_len = token_len + 15'd1;
      parse_phase = phase_type'({tok, 1'b1});
      r.result_kind = hrlt_pkg::KIND_BYTE;
      r.token_byte = b;
      return 1'b1;
   endfunction

   function automatic bit tokenize(input hrlt_pkg::req_item_type it,
                                   output hrlt_pkg::rsp_item_type r);
      logic [1:0] tok;
      r = '0;
      if (it.restart) begin
         parse_phase = SEEK_METHOD;
         token_len = '0;
      end
      tok = parse_phase[2:1];
      case (parse_phase)
         SEEK_METHOD, SEEK_URI, SEEK_VERSION: begin
            if (it.end_of_stream) begin
               parse_phase = STOPPED;
               r.result_kind = hrlt_pkg::KIND_ERROR;
               r.token_id = tok;
               r.error_code = (tok == hrlt_pkg::TOK_METHOD) ?
                              hrlt_pkg::ERR_NO_HEADER : bad_token_code(tok);
               return 1'b1;
            end
            if (is_space(it.data_byte)) return 1'b0;
            token_len = '0;
            return take_token_byte(tok, it.data_byte, r);
         end
         IN_METHOD, IN_URI, IN_VERSION: begin
            if (it.end_of_stream) begin
               parse_phase = STOPPED;
               r.result_kind = hrlt_pkg::KIND_ERROR;
               r.token_id = tok;
               r.error_code = bad_token_code(tok);
               return 1'b1;
            end
            if (!is_space(it.data_byte)) return take_token_byte(tok, it.data_byte, r);
            token_len = '0;
            r.result_kind = hrlt_pkg::KIND_END;
            r.token_id = tok;
            if (tok == hrlt_pkg::TOK_VERSION) begin
               if (it.data_byte == hrlt_pkg::LF_BYTE) begin
                  parse_phase = STOPPED;
                  r.line_done = 1'b1;
               end else begin
                  parse_phase = DISCARD_LINE;
               end
            end else begin
               parse_phase = phase_type'(parse_phase + 3'd1);
            end
            return 1'b1;
         end
         DISCARD_LINE: begin
            if (it.end_of_stream || it.data_byte == hrlt_pkg::LF_BYTE) begin
               parse_phase = STOPPED;
               r.result_kind = hrlt_pkg::KIND_LINE;
               r.token_id = hrlt_pkg::TOK_VERSION;
               r.line_done = 1'b1;
               return 1'b1;
            end
            return 1'b0;
         end
         default: begin
            parse_phase = STOPPED;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic push_item(input logic [7:0] b, input bit eos, input bit rs);
      entry_type e;
      e.kind = ENTRY_ITEM;
      e.item.data_byte = b;
      e.item.end_of_stream = eos;
      e.item.restart = rs;
      e.csr_index = '0;
      e.csr_value = '0;
      pending_entries.push_back(e);
      planned_items++;
   endtask

   task automatic push_csr(input logic [1:0] idx, input int value);
      entry_type e;
      e.kind = ENTRY_CSR;
      e.item = '0;
      e.csr_index = idx;
      e.csr_value = value[14:0];
      pending_entries.push_back(e);
      gen_lim[idx] = value;
   endtask

   task automatic push_drain();
      entry_type e;
      e.kind = ENTRY_DRAIN;
      e.item = '0;
      e.csr_index = '0;
      e.csr_value = '0;
      pending_entries.push_back(e);
   endtask

   task automatic push_limits(input int m, input int u, input int v);
      push_csr(hrlt_pkg::CSR_MAX_METHOD_LEN, m);
      push_csr(hrlt_pkg::CSR_MAX_URI_LEN, u);
      push_csr(hrlt_pkg::CSR_MAX_VERSION_LEN, v);
   endtask

   // The first item of a line carries the planned restart; a stray restart
   // now and then lands in the middle of a line.
   task automatic add_byte(input logic [7:0] b, input bit eos);
      bit rs;
      rs = restart_next || ($urandom_range(0, 149) == 0);
      restart_next = 1'b0;
      push_item(b, eos, rs);
   endtask

   function automatic logic [7:0] white_byte(input bit allow_lf);
      logic [7:0] b;
      do begin
         b = ($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
      end while (!allow_lf && b == hrlt_pkg::LF_BYTE);
      return b;
   endfunction

   function automatic logic [7:0] solid_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (is_space(b));
      return b;
   endfunction

   task automatic gen_line();
      int n;
      int lim;
      int pick;
      logic [7:0] b;
      restart_next = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 8))
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         return;
      end
      repeat ($urandom_range(0, 2)) add_byte(white_byte(1'b1), 1'b0);
      for (int t = 0; t < 3; t++) begin
         lim = gen_lim[t];
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            n = $urandom_range(1, (lim < 6) ? lim : 6);
         end else if (pick < 85) begin
            n = (lim <= 24) ? lim : 6;
         end else if (pick < 95) begin
            n = (lim <= 24) ? lim + 1 : 7;
         end else begin
            repeat ($urandom_range(0, 2)) add_byte(solid_byte(), 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b1);
            return;
         end
         repeat (n) add_byte(solid_byte(), 1'b0);
         if (t < 2) begin
            repeat ($urandom_range(1, 2)) add_byte(white_byte(1'b1), 1'b0);
            if ($urandom_range(0, 19) == 0) begin
               add_byte(8'($urandom_range(0, 255)), 1'b1);
               return;
            end
         end else if ($urandom_range(0, 1) == 0) begin
            add_byte(hrlt_pkg::LF_BYTE, 1'b0);
         end else begin
            add_byte(white_byte(1'b0), 1'b0);
            repeat ($urandom_range(0, 3)) begin
               do begin
                  b = 8'($urandom_range(0, 255));
               end while (b == hrlt_pkg::LF_BYTE);
               add_byte(b, 1'b0);
            end
            if ($urandom_range(0, 4) != 0) add_byte(hrlt_pkg::LF_BYTE, 1'b0);
            else add_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // Sender: items go out from the pending queue; register writes and drain
   // markers wait until the block has gone quiet.
   always @(posedge clock) begin
      logic next_valid;
      logic next_we;
      entry_type head;
      hrlt_pkg::rsp_item_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b0;
         send_gap <= 0;
         settle <= 0;
      end else begin
         next_valid = req_tvalid;
         next_we = 1'b0;
         if (req_tvalid && req_tready) begin
            if (tokenize(in_flight, r)) expected_results.push_back(r);
            next_valid = 1'b0;
         end
         if ((req_tvalid && req_tready) || expected_results.size() != 0) settle <= 0;
         else settle <= settle + 1;
         if (!next_valid && pending_entries.size() != 0) begin
            head = pending_entries[0];
            if (head.kind == ENTRY_ITEM) begin
               if (send_gap != 0) begin
                  send_gap <= send_gap - 1;
               end else begin
                  void'(pending_entries.pop_front());
                  in_flight <= head.item;
                  req_tdata <= head.item.data_byte;
                  req_tlast <= head.item.end_of_stream;
                  req_tuser <= head.item.restart;
                  next_valid = 1'b1;
                  if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                  send_gap <= send_calm ? 0 : $urandom_range(0, 19);
               end
            end else if (expected_results.size() == 0 && settle >= SETTLE_CYCLES) begin
               void'(pending_entries.pop_front());
               if (head.kind == ENTRY_CSR) begin
                  next_we = 1'b1;
                  csr_index <= head.csr_index;
                  csr_wdata <= head.csr_value;
                  case (head.csr_index)
                     hrlt_pkg::CSR_MAX_METHOD_LEN:  lim_method = head.csr_value[7:0];
                     hrlt_pkg::CSR_MAX_URI_LEN:     lim_uri = head.csr_value;
                     hrlt_pkg::CSR_MAX_VERSION_LEN: lim_version = head.csr_value[7:0];
                     default: ;
                  endcase
               end
            end
         end
         req_tvalid <= next_valid;
         csr_we <= next_we;
      end
   end

   // Receiver: checks each result against the oldest prediction.
   always @(posedge clock) begin
      hrlt_pkg::rsp_item_type got;
      hrlt_pkg::rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_off = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.result_kind = rsp_tuser;
            got.token_id = rsp_tdata[1:0];
            got.token_byte = rsp_tdata[9:2];
            got.error_code = rsp_tdata[11:10];
            got.line_done = rsp_tlast;
            if (expected_results.size() == 0) begin
               $error("unexpected result: result_kind %0d token_id %0d",
                      got.result_kind, got.token_id);
               failures++;
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", want.result_kind, got.result_kind);
               check_field("token_id", want.token_id, got.token_id);
               check_field("token_byte", want.token_byte, got.token_byte);
               check_field("error_code", want.error_code, got.error_code);
               check_field("line_done", want.line_done, got.line_done);
            end
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            hold_off = recv_calm ? 0 : $urandom_range(0, 19);
         end
         if (hold_off != 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      gen_lim[0] = hrlt_pkg::RESET_MAX_METHOD_LEN;
      gen_lim[1] = hrlt_pkg::RESET_MAX_URI_LEN;
      gen_lim[2] = hrlt_pkg::RESET_MAX_VERSION_LEN;

      // Directed part with tight limits so that the too-long cases come early.
      push_limits(1, 2, 1);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b0, 1'b1);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'h20, 1'b0, 1'b1);
      push_item(8'h4D, 1'b0, 1'b0);
      push_item(8'h09, 1'b0, 1'b0);
      push_item(8'h0D, 1'b0, 1'b0);
      push_item(8'h80, 1'b0, 1'b0);
      push_item(8'h7F, 1'b0, 1'b0);
      push_item(8'h0B, 1'b0, 1'b0);
      push_item(8'h0C, 1'b0, 1'b0);
      push_item(8'h56, 1'b0, 1'b0);
      push_item(8'h20, 1'b0, 1'b0);
      push_item(8'h41, 1'b0, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'h0A, 1'b1, 1'b0);
      push_item(8'h61, 1'b0, 1'b1);
      push_item(8'h0A, 1'b0, 1'b0);
      push_item(8'h62, 1'b0, 1'b0);
      push_item(8'h20, 1'b0, 1'b0);
      push_item(8'h76, 1'b0, 1'b0);
      push_item(8'h0A, 1'b0, 1'b0);
      push_item(8'h64, 1'b0, 1'b1);
      push_item(8'h20, 1'b0, 1'b0);
      push_item(8'h31, 1'b1, 1'b0);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: push_limits(255, 32767, 255);
            1: push_limits(1, 1, 1);
            2: push_limits($urandom_range(1, 10), $urandom_range(1, 12), $urandom_range(1, 10));
            3: push_limits($urandom_range(1, 255), $urandom_range(1, 32767),
                           $urandom_range(1, 255));
            4: push_limits($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
            default: push_limits(2, 3, 2);
         endcase
         for (int k = planned_items; planned_items < k + RANDOM_ITEMS / 6;) begin
            gen_line();
            if (p == 2 && planned_items >= k + RANDOM_ITEMS / 12 && $urandom_range(0, 3) == 0)
               push_drain();
         end
      end
      push_drain();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_entries.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
